// ===== hdl/cds_pkg.sv =====
// ----------------------------------------------------------------------------
// cds_pkg
// Shared types, constants and calendar helper functions for the date stepper.
// ----------------------------------------------------------------------------
package cds_pkg;

  // Field widths
  localparam int unsigned YEAR_W  = 14;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned DAY_W   = 5;
  localparam int unsigned WDAY_W  = 3;
  localparam int unsigned CMD_W   = 3;
  localparam int unsigned YMOD_W  = 9;   // year modulo 400

  // Year range and reset date
  localparam logic [YEAR_W-1:0]  YEAR_MIN  = 14'd1;
  localparam logic [YEAR_W-1:0]  YEAR_MAX  = 14'd9999;
  localparam logic [YEAR_W-1:0]  YEAR_RST  = 14'd2000;
  localparam logic [YMOD_W-1:0]  YMOD_RST  = 9'd0;     // 2000 mod 400
  localparam logic [YMOD_W-1:0]  YMOD_TOP  = 9'd399;
  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_MAR = 4'd3;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;
  localparam logic [DAY_W-1:0]   DAY_FIRST = 5'd1;
  localparam logic [DAY_W-1:0]   DAY_DEC31 = 5'd31;

  // Command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD       = 3'd0,
    CMD_NEXT_DAY   = 3'd1,
    CMD_PREV_DAY   = 3'd2,
    CMD_NEXT_MONTH = 3'd3,
    CMD_PREV_MONTH = 3'd4,
    CMD_NEXT_YEAR  = 3'd5,
    CMD_PREV_YEAR  = 3'd6
  } cmd_e;

  // Registered command, with the load date already checked
  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    logic [YMOD_W-1:0]  ymod;
    logic               load_ok;
  } cmd_t;

  // Date after a step, with its year modulo 400 and the refusal flag
  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    logic [YMOD_W-1:0]  ymod;
    logic               err;
  } date_t;

  // Leap year from the year modulo 400 (4/100/400 rule)
  function automatic logic leap_of(input logic [YMOD_W-1:0] r);
    return (r[1:0] == 2'd0) && (r != 9'd100) && (r != 9'd200) && (r != 9'd300);
  endfunction

  function automatic logic [YMOD_W-1:0] ymod_inc(input logic [YMOD_W-1:0] r);
    return (r == YMOD_TOP) ? '0 : r + 9'd1;
  endfunction

  function automatic logic [YMOD_W-1:0] ymod_dec(input logic [YMOD_W-1:0] r);
    return (r == '0) ? YMOD_TOP : r - 9'd1;
  endfunction

  // Month length; zero for a month code outside 1..12
  function automatic logic [DAY_W-1:0] month_days(input logic leap,
                                                  input logic [MONTH_W-1:0] m);
    logic [DAY_W-1:0] len;
    unique case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                       len = leap ? 5'd29 : 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

  // Month offset of the weekday formula
  function automatic logic [WDAY_W-1:0] sak_offset(input logic [MONTH_W-1:0] m);
    logic [WDAY_W-1:0] ofs;
    unique case (m)
      4'd1:    ofs = 3'd0;
      4'd2:    ofs = 3'd3;
      4'd3:    ofs = 3'd2;
      4'd4:    ofs = 3'd5;
      4'd5:    ofs = 3'd0;
      4'd6:    ofs = 3'd3;
      4'd7:    ofs = 3'd5;
      4'd8:    ofs = 3'd1;
      4'd9:    ofs = 3'd4;
      4'd10:   ofs = 3'd6;
      4'd11:   ofs = 3'd2;
      4'd12:   ofs = 3'd4;
      default: ofs = 3'd0;
    endcase
    return ofs;
  endfunction

  // Year modulo 400: quotient of (y >> 4) by 25 through a scaled reciprocal
  function automatic logic [YMOD_W-1:0] mod400(input logic [YEAR_W-1:0] y);
    logic [9:0]        x;
    logic [21:0]       prod;
    logic [5:0]        q;
    logic [YEAR_W-1:0] qx;
    x    = y[13:4];
    prod = 22'(x) * 22'd2622;
    q    = prod[21:16];
    qx   = (14'(q) << 8) + (14'(q) << 7) + (14'(q) << 4);
    return 9'(y - qx);
  endfunction

endpackage

// ===== hdl/cds_ingress.sv =====
// ----------------------------------------------------------------------------
// cds_ingress
// Input register: captures a command and checks the load date on the way in.
// ----------------------------------------------------------------------------
module cds_ingress (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  output logic                          ready_o,
  input  logic [cds_pkg::CMD_W-1:0]     cmd_i,
  input  logic [cds_pkg::YEAR_W-1:0]    year_i,
  input  logic [cds_pkg::MONTH_W-1:0]   month_i,
  input  logic [cds_pkg::DAY_W-1:0]     day_i,
  output logic                          valid_o,
  input  logic                          ready_i,
  output cds_pkg::cmd_t                 cmd_o
);

  logic                         valid_q;
  cds_pkg::cmd_t                cmd_q, cmd_d;
  logic [cds_pkg::DAY_W-1:0]    load_len;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign cmd_o   = cmd_q;

  // Check the load date against its month length
  always_comb begin
    cmd_d.cmd   = cmd_i;
    cmd_d.year  = year_i;
    cmd_d.month = month_i;
    cmd_d.day   = day_i;
    cmd_d.ymod  = cds_pkg::mod400(year_i);
    load_len    = cds_pkg::month_days(cds_pkg::leap_of(cmd_d.ymod), month_i);
    cmd_d.load_ok = (year_i >= cds_pkg::YEAR_MIN) && (year_i <= cds_pkg::YEAR_MAX) &&
                    (load_len != '0) && (day_i != '0) && (day_i <= load_len);
  end

  // Hold the valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // Capture the command on a transfer
  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      cmd_q <= cmd_d;
    end
  end

endmodule

// ===== hdl/cds_step.sv =====
// ----------------------------------------------------------------------------
// cds_step
// Date register and the update for every command.
// ----------------------------------------------------------------------------
module cds_step (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  output logic          ready_o,
  input  cds_pkg::cmd_t cmd_i,
  output logic          valid_o,
  input  logic          ready_i,
  output cds_pkg::date_t date_o
);

  logic                          valid_q;
  logic [cds_pkg::YEAR_W-1:0]    year_q, year_d;
  logic [cds_pkg::MONTH_W-1:0]   month_q, month_d;
  logic [cds_pkg::DAY_W-1:0]     day_q, day_d;
  logic [cds_pkg::YMOD_W-1:0]    ymod_q, ymod_d;
  logic                          err_q, err_d;
  logic                          leap_cur, leap_nxt, leap_prv;
  logic [cds_pkg::DAY_W-1:0]     old_len, new_len;
  logic                          move;
  logic                          tgt_leap;
  logic [cds_pkg::MONTH_W-1:0]   tgt_month;
  logic                          step;

  assign ready_o = !valid_q || ready_i;
  assign step    = valid_i && ready_o;
  assign valid_o = valid_q;
  assign date_o  = '{year: year_q, month: month_q, day: day_q, ymod: ymod_q, err: err_q};

  // Work out the next date
  always_comb begin
    leap_cur  = cds_pkg::leap_of(ymod_q);
    leap_nxt  = cds_pkg::leap_of(cds_pkg::ymod_inc(ymod_q));
    leap_prv  = cds_pkg::leap_of(cds_pkg::ymod_dec(ymod_q));
    old_len   = cds_pkg::month_days(leap_cur, month_q);
    year_d    = year_q;
    month_d   = month_q;
    day_d     = day_q;
    ymod_d    = ymod_q;
    err_d     = 1'b0;
    move      = 1'b0;
    tgt_leap  = leap_cur;
    tgt_month = month_q;

    unique case (cmd_i.cmd)
      cds_pkg::CMD_LOAD: begin
        if (cmd_i.load_ok) begin
          year_d  = cmd_i.year;
          month_d = cmd_i.month;
          day_d   = cmd_i.day;
          ymod_d  = cmd_i.ymod;
        end else begin
          err_d = 1'b1;
        end
      end
      cds_pkg::CMD_NEXT_DAY: begin
        priority if (day_q < old_len) begin
          day_d = day_q + 5'd1;
        end else if (month_q < cds_pkg::MONTH_DEC) begin
          month_d = month_q + 4'd1;
          day_d   = cds_pkg::DAY_FIRST;
        end else if (year_q < cds_pkg::YEAR_MAX) begin
          year_d  = year_q + 14'd1;
          ymod_d  = cds_pkg::ymod_inc(ymod_q);
          month_d = cds_pkg::MONTH_JAN;
          day_d   = cds_pkg::DAY_FIRST;
        end else begin
          err_d = 1'b1;
        end
      end
      cds_pkg::CMD_PREV_DAY: begin
        priority if (day_q > cds_pkg::DAY_FIRST) begin
          day_d = day_q - 5'd1;
        end else if (month_q > cds_pkg::MONTH_JAN) begin
          month_d = month_q - 4'd1;
          day_d   = cds_pkg::month_days(leap_cur, month_q - 4'd1);
        end else if (year_q > cds_pkg::YEAR_MIN) begin
          year_d  = year_q - 14'd1;
          ymod_d  = cds_pkg::ymod_dec(ymod_q);
          month_d = cds_pkg::MONTH_DEC;
          day_d   = cds_pkg::DAY_DEC31;
        end else begin
          err_d = 1'b1;
        end
      end
      cds_pkg::CMD_NEXT_MONTH: begin
        priority if (month_q < cds_pkg::MONTH_DEC) begin
          move      = 1'b1;
          tgt_month = month_q + 4'd1;
        end else if (year_q < cds_pkg::YEAR_MAX) begin
          move      = 1'b1;
          year_d    = year_q + 14'd1;
          ymod_d    = cds_pkg::ymod_inc(ymod_q);
          tgt_leap  = leap_nxt;
          tgt_month = cds_pkg::MONTH_JAN;
        end else begin
          err_d = 1'b1;
        end
      end
      cds_pkg::CMD_PREV_MONTH: begin
        priority if (month_q > cds_pkg::MONTH_JAN) begin
          move      = 1'b1;
          tgt_month = month_q - 4'd1;
        end else if (year_q > cds_pkg::YEAR_MIN) begin
          move      = 1'b1;
          year_d    = year_q - 14'd1;
          ymod_d    = cds_pkg::ymod_dec(ymod_q);
          tgt_leap  = leap_prv;
          tgt_month = cds_pkg::MONTH_DEC;
        end else begin
          err_d = 1'b1;
        end
      end
      cds_pkg::CMD_NEXT_YEAR: begin
        if (year_q < cds_pkg::YEAR_MAX) begin
          move     = 1'b1;
          year_d   = year_q + 14'd1;
          ymod_d   = cds_pkg::ymod_inc(ymod_q);
          tgt_leap = leap_nxt;
        end else begin
          err_d = 1'b1;
        end
      end
      cds_pkg::CMD_PREV_YEAR: begin
        if (year_q > cds_pkg::YEAR_MIN) begin
          move     = 1'b1;
          year_d   = year_q - 14'd1;
          ymod_d   = cds_pkg::ymod_dec(ymod_q);
          tgt_leap = leap_prv;
        end else begin
          err_d = 1'b1;
        end
      end
      default: begin
        err_d = 1'b1;
      end
    endcase

    // Keep end of month, otherwise clamp to the new month's length
    new_len = cds_pkg::month_days(tgt_leap, tgt_month);
    if (move) begin
      month_d = tgt_month;
      day_d   = ((day_q == old_len) || (day_q > new_len)) ? new_len : day_q;
    end
  end

  // Hold the date and the result valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      year_q  <= cds_pkg::YEAR_RST;
      month_q <= cds_pkg::MONTH_JAN;
      day_q   <= cds_pkg::DAY_FIRST;
      ymod_q  <= cds_pkg::YMOD_RST;
    end else begin
      if (ready_o) begin
        valid_q <= valid_i;
      end
      if (step) begin
        year_q  <= year_d;
        month_q <= month_d;
        day_q   <= day_d;
        ymod_q  <= ymod_d;
      end
    end
  end

  // Capture the refusal flag with the step
  always_ff @(posedge clk_i) begin
    if (step) begin
      err_q <= err_d;
    end
  end

endmodule

// ===== hdl/cds_result.sv =====
// ----------------------------------------------------------------------------
// cds_result
// Output register: adds weekday and leap flag to the stepped date.
// ----------------------------------------------------------------------------
module cds_result (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  output logic                          ready_o,
  input  cds_pkg::date_t                date_i,
  output logic                          valid_o,
  input  logic                          ready_i,
  output logic [cds_pkg::YEAR_W-1:0]    year_o,
  output logic [cds_pkg::MONTH_W-1:0]   month_o,
  output logic [cds_pkg::DAY_W-1:0]     day_o,
  output logic [cds_pkg::WDAY_W-1:0]    weekday_o,
  output logic                          leap_o,
  output logic                          err_o
);

  logic                          valid_q;
  logic [cds_pkg::YEAR_W-1:0]    year_q;
  logic [cds_pkg::MONTH_W-1:0]   month_q;
  logic [cds_pkg::DAY_W-1:0]     day_q;
  logic [cds_pkg::WDAY_W-1:0]    wday_q, wday_d;
  logic                          leap_q;
  logic                          err_q;
  logic [cds_pkg::YMOD_W-1:0]    wy;
  logic [1:0]                    cent;
  logic [9:0]                    sum;
  logic [17:0]                   prod;
  logic [6:0]                    quo;

  assign ready_o   = !valid_q || ready_i;
  assign valid_o   = valid_q;
  assign year_o    = year_q;
  assign month_o   = month_q;
  assign day_o     = day_q;
  assign weekday_o = wday_q;
  assign leap_o    = leap_q;
  assign err_o     = err_q;

  // Weekday from the year modulo 400; whole 400-year cycles add a multiple of 7
  always_comb begin
    wy   = (date_i.month < cds_pkg::MONTH_MAR) ? cds_pkg::ymod_dec(date_i.ymod)
                                               : date_i.ymod;
    cent = {1'b0, wy >= 9'd100} + {1'b0, wy >= 9'd200} + {1'b0, wy >= 9'd300};
    sum  = 10'(wy) + 10'(wy[8:2]) - 10'(cent) +
           10'(cds_pkg::sak_offset(date_i.month)) + 10'(date_i.day);
    prod = 18'(sum) * 18'd293;
    quo  = prod[17:11];
    wday_d = 3'(sum - ((10'(quo) << 3) - 10'(quo)));
  end

  // Hold the valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // Capture the result on a transfer from the step stage
  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      year_q  <= date_i.year;
      month_q <= date_i.month;
      day_q   <= date_i.day;
      wday_q  <= wday_d;
      leap_q  <= cds_pkg::leap_of(date_i.ymod);
      err_q   <= date_i.err;
    end
  end

endmodule

// ===== hdl/calendar_date_stepper_core.sv =====
// ----------------------------------------------------------------------------
// calendar_date_stepper_core
// Gregorian date register (years 1..9999) stepped by one command per transfer.
// ----------------------------------------------------------------------------
// Slave stream: one command per transfer; tuser carries the command code
// (load, next/previous day, month or year), tdata the date used by a load.
// Master stream: one result per command: the date after the step, its day of
// week (0 Sunday), the leap-year flag and an error flag. A refused command
// (bad load date, a step past 0001-01-01 or 9999-12-31, unused code) leaves
// the date unchanged and sets the error flag.
// Three register stages: input register, date update, output register. A
// result reaches the master side through the input register, the date
// register and the output register in that order. One command is taken
// every cycle while the receiver accepts results; the date register is read
// and written in the same cycle, so each command sees the one before it.
// Reset sets the date to 2000-01-01 and empties all stages.
// When the receiver stalls, the output register holds its result; stages
// behind it keep filling until each holds a command, then tready drops.
// ----------------------------------------------------------------------------
module calendar_date_stepper_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [13:0] load_year, [17:14] load_month, [22:18] load_day, [23] zero
  input  logic [23:0] s_axis_tdata,
  // [2:0] cmd
  input  logic [2:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [13:0] date_year, [17:14] date_month, [22:18] date_day, [25:23] weekday,
  // [26] leap_flag, [27] error_flag, [31:28] zero
  output logic [31:0] m_axis_tdata
);

  logic                          a_valid, a_ready;
  cds_pkg::cmd_t                 a_cmd;
  logic                          b_valid, b_ready;
  cds_pkg::date_t                b_date;
  logic [cds_pkg::YEAR_W-1:0]    r_year;
  logic [cds_pkg::MONTH_W-1:0]   r_month;
  logic [cds_pkg::DAY_W-1:0]     r_day;
  logic [cds_pkg::WDAY_W-1:0]    r_wday;
  logic                          r_leap, r_err;

  // Input register
  cds_ingress u_ingress (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .cmd_i   (s_axis_tuser),
    .year_i  (s_axis_tdata[13:0]),
    .month_i (s_axis_tdata[17:14]),
    .day_i   (s_axis_tdata[22:18]),
    .valid_o (a_valid),
    .ready_i (a_ready),
    .cmd_o   (a_cmd)
  );

  // Date update
  cds_step u_step (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (a_valid),
    .ready_o (a_ready),
    .cmd_i   (a_cmd),
    .valid_o (b_valid),
    .ready_i (b_ready),
    .date_o  (b_date)
  );

  // Output register
  cds_result u_result (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (b_valid),
    .ready_o   (b_ready),
    .date_i    (b_date),
    .valid_o   (m_axis_tvalid),
    .ready_i   (m_axis_tready),
    .year_o    (r_year),
    .month_o   (r_month),
    .day_o     (r_day),
    .weekday_o (r_wday),
    .leap_o    (r_leap),
    .err_o     (r_err)
  );

  // Pack the result
  assign m_axis_tdata = {4'b0000, r_err, r_leap, r_wday, r_day, r_month, r_year};

  // The stepped month is always in 1..12 and the stepped day is never zero
  a_month_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_valid |-> (b_date.month >= cds_pkg::MONTH_JAN) &&
                (b_date.month <= cds_pkg::MONTH_DEC) && (b_date.day != '0))
    else $error("stepped month or day out of range");

  // Year stays in range and its modulo-400 tag stays within 0..399
  a_year_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_valid |-> (b_date.year >= cds_pkg::YEAR_MIN) &&
                (b_date.year <= cds_pkg::YEAR_MAX) &&
                (b_date.ymod <= cds_pkg::YMOD_TOP))
    else $error("stepped year out of range");

  // A result only appears after the step stage held one
  a_out_source : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(b_valid))
    else $error("result without a stepped date");

endmodule
